[rtl/dgsp_pkg.sv]
// ----------------------------------------------------------------------------
// dgsp_pkg: shared types and constants for the dense-graph shortest path block
// Transaction payloads, command codes and the request/result of the shared
// compare/add unit.
// ----------------------------------------------------------------------------
package dgsp_pkg;

  localparam int NODES_DEF = 64;   // default node count
  localparam int NODE_W    = 6;    // node index field width on the ports
  localparam int WEIGHT_W  = 8;    // edge weight width
  localparam int DIST_W    = 16;   // path distance width
  localparam int MAX_RPT   = 64;   // at most this many nodes are reported

  localparam logic [DIST_W-1:0] INF_DIST = '1;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // shared unit modes
  localparam logic ALU_SELECT = 1'b0;
  localparam logic ALU_RELAX  = 1'b1;

  typedef struct packed {
    logic                command;
    logic [NODE_W-1:0]   from_node;
    logic [NODE_W-1:0]   to_node;
    logic [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]   source;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] distance;
    logic              reachable;
    logic [NODE_W-1:0] parent;
    logic              has_parent;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic                mode;
    logic                settled;
    logic [DIST_W-1:0]   cur_dist;
    logic [DIST_W-1:0]   best;
    logic                best_vld;
    logic [DIST_W-1:0]   du;
    logic [WEIGHT_W-1:0] weight;
  } alu_req_t;

  typedef struct packed {
    logic              take;
    logic              upd;
    logic [DIST_W-1:0] cand;
  } alu_res_t;

endpackage

[rtl/dgsp_alu.sv]
// ----------------------------------------------------------------------------
// dgsp_alu: shared compare/add unit
// One adder and one magnitude compare, used for minimum selection during the
// scan and for edge relaxation.
// ----------------------------------------------------------------------------
module dgsp_alu (
  input  dgsp_pkg::alu_req_t req,
  output dgsp_pkg::alu_res_t res
);
  import dgsp_pkg::*;

  logic [DIST_W:0] sum;
  logic [DIST_W:0] lhs;
  logic            ge;

  assign sum = {1'b0, req.du} + {{(DIST_W + 1 - WEIGHT_W){1'b0}}, req.weight};

  always_comb begin
    case (req.mode)
      ALU_RELAX: lhs = sum;
      default:   lhs = {1'b0, req.best};
    endcase
  end

  assign ge = lhs >= {1'b0, req.cur_dist};

  always_comb begin
    res.take = 1'b0;
    res.upd  = 1'b0;
    res.cand = sum[DIST_W-1:0];
    case (req.mode)
      ALU_SELECT: res.take = !req.settled && (!req.best_vld || ge);
      ALU_RELAX:  res.upd  = !req.settled && (req.weight != '0) && !ge;
      default: begin
        res.take = 1'b0;
        res.upd  = 1'b0;
      end
    endcase
  end

endmodule

[rtl/dgsp_report.sv]
// ----------------------------------------------------------------------------
// dgsp_report: result formatting and output register
// Turn one node's stored state into a result transaction and hold it until
// the receiver takes it.
// ----------------------------------------------------------------------------
module dgsp_report #(
  parameter int NODES = dgsp_pkg::NODES_DEF,
  parameter int IDX_W = $clog2(NODES),
  parameter int PRED_W = IDX_W + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic [IDX_W-1:0]         k,
  input  logic [dgsp_pkg::DIST_W-1:0] node_dist,
  input  logic [PRED_W-1:0]        pred,
  input  logic                     last,
  output logic                     free,
  output logic                     out_valid,
  input  logic                     out_ready,
  output dgsp_pkg::out_item_t      out_item
);
  import dgsp_pkg::*;

  logic      valid_r;
  out_item_t item_r;
  out_item_t item_nxt;
  logic      reach;
  logic      hp;

  assign reach = node_dist != INF_DIST;
  assign hp    = reach && (pred < PRED_W'(NODES));

  always_comb begin
    item_nxt.node       = NODE_W'(k);
    item_nxt.distance   = reach ? node_dist : '0;
    item_nxt.reachable  = reach;
    item_nxt.parent     = hp ? NODE_W'(pred) : '0;
    item_nxt.has_parent = hp;
    item_nxt.last       = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

[rtl/dense_graph_shortest_path.sv]
// ----------------------------------------------------------------------------
// dense_graph_shortest_path: single-source shortest paths over an adjacency
// matrix, with one shared compare/add unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready input channel. A load transaction (command 0) writes
//           one edge weight (0 = no edge); writes with from_node or to_node
//           at or above NODES are dropped.
//           A run transaction (command 1) starts a search from source.
//   out_* : valid/ready result channel, one transaction per node 0..63 (or
//           0..NODES-1 if fewer), in index order, last set on the final one.
// A run: the node store is first initialized, then NODES-1 rounds follow,
//   each a scan and, when the chosen node is reachable, a relaxation pass.
//   Results then leave one at a time, each node read from the node store
//   and then loaded into the output register. in_ready stays low for the
//   whole run.
// Reset: a clearing pass zeroes the edge matrix, one entry per cycle;
//   in_ready stays low until it ends.
// Stalls: a result waits in the output register while out_ready is low and
//   the sequencer holds the next node read until the register frees.
// ----------------------------------------------------------------------------
module dense_graph_shortest_path #(
  parameter int NODES = dgsp_pkg::NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dgsp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output dgsp_pkg::out_item_t out_item
);
  import dgsp_pkg::*;

  localparam int IDX_W   = $clog2(NODES);
  localparam int PRED_W  = IDX_W + 1;          // holds NODES as "no parent"
  localparam int WORD_W  = 1 + PRED_W + DIST_W; // {settled, pred, dist}
  localparam int EDGES   = NODES * NODES;
  localparam int EA_W    = $clog2(EDGES);
  localparam int RPT_CNT = (NODES < MAX_RPT) ? NODES : MAX_RPT;

  localparam logic [IDX_W-1:0]  V_LAST     = IDX_W'(NODES - 1);
  localparam logic [IDX_W-1:0]  ROUND_LAST = IDX_W'(NODES - 2);
  localparam logic [IDX_W-1:0]  RPT_LAST   = IDX_W'(RPT_CNT - 1);
  localparam logic [EA_W-1:0]   EA_LAST    = EA_W'(EDGES - 1);
  localparam logic [PRED_W-1:0] PRED_NONE  = PRED_W'(NODES);

  // sequencer states
  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_INIT      = 4'd2;
  localparam logic [3:0] S_SCAN      = 4'd3;
  localparam logic [3:0] S_SCAN_END  = 4'd4;
  localparam logic [3:0] S_MARK      = 4'd5;
  localparam logic [3:0] S_RELAX     = 4'd6;
  localparam logic [3:0] S_RELAX_END = 4'd7;
  localparam logic [3:0] S_REP_RD    = 4'd8;
  localparam logic [3:0] S_REP_LD    = 4'd9;

  // edge matrix and per-node state
  logic [WEIGHT_W-1:0] edge_mem [EDGES];
  logic [WORD_W-1:0]   node_mem [NODES];

  logic [3:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    v_r, v_nxt;          // node counter (init, scan, relax, report)
  logic [IDX_W-1:0]    round_r, round_nxt;
  logic [EA_W-1:0]     ea_r, ea_nxt;        // edge address (clear sweep, relax row)
  logic [NODE_W-1:0]   src_r, src_nxt;
  logic [DIST_W-1:0]   best_r, best_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  logic [PRED_W-1:0]   best_pred_r, best_pred_nxt;
  logic                best_vld_r, best_vld_nxt;
  logic [DIST_W-1:0]   du_r, du_nxt;
  logic                p_vld_r, p_vld_nxt;  // read data valid next cycle
  logic [IDX_W-1:0]    p_idx_r, p_idx_nxt;

  logic                nwr_en, nrd_en;
  logic [IDX_W-1:0]    nwr_addr, nrd_addr;
  logic [WORD_W-1:0]   nwr_data, nrd_r;
  logic                ewr_en, erd_en;
  logic [EA_W-1:0]     ewr_addr;
  logic [WEIGHT_W-1:0] ewr_data, erd_r;

  logic                n_set;
  logic [PRED_W-1:0]   n_pred;
  logic [DIST_W-1:0]   n_dist;

  alu_req_t            alu_req;
  alu_res_t            alu_res;

  logic                rpt_free, rpt_load;

  assign n_set  = nrd_r[WORD_W-1];
  assign n_pred = nrd_r[DIST_W +: PRED_W];
  assign n_dist = nrd_r[DIST_W-1:0];

  // shared compare/add unit: select mode during scan, relax mode during relax
  always_comb begin
    alu_req.mode     = ((state_r == S_RELAX) || (state_r == S_RELAX_END)) ?
                       ALU_RELAX : ALU_SELECT;
    alu_req.settled  = n_set;
    alu_req.cur_dist = n_dist;
    alu_req.best     = best_r;
    alu_req.best_vld = best_vld_r;
    alu_req.du       = du_r;
    alu_req.weight   = erd_r;
  end

  dgsp_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    round_nxt     = round_r;
    ea_nxt        = ea_r;
    src_nxt       = src_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    best_pred_nxt = best_pred_r;
    best_vld_nxt  = best_vld_r;
    du_nxt        = du_r;
    p_vld_nxt     = 1'b0;
    p_idx_nxt     = p_idx_r;
    nwr_en        = 1'b0;
    nwr_addr      = v_r;
    nwr_data      = '0;
    nrd_en        = 1'b0;
    nrd_addr      = v_r;
    ewr_en        = 1'b0;
    ewr_addr      = ea_r;
    ewr_data      = '0;
    erd_en        = 1'b0;
    rpt_load      = 1'b0;

    // data returning from the node store: fold into the running minimum,
    // or write back an improved distance
    if (p_vld_r && alu_res.take) begin
      best_nxt      = n_dist;
      best_idx_nxt  = p_idx_r;
      best_pred_nxt = n_pred;
      best_vld_nxt  = 1'b1;
    end
    if (p_vld_r && alu_res.upd) begin
      nwr_en   = 1'b1;
      nwr_addr = p_idx_r;
      nwr_data = {1'b0, PRED_W'(best_idx_r), alu_res.cand};
    end

    case (state_r)
      S_CLEAR: begin
        ewr_en = 1'b1;
        ea_nxt = ea_r + 1'b1;
        if (ea_r == EA_LAST) begin
          ea_nxt    = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_item.command == CMD_LOAD) begin
            ewr_en   = (32'(in_item.from_node) < NODES) && (32'(in_item.to_node) < NODES);
            ewr_addr = EA_W'(32'(in_item.from_node) * NODES + 32'(in_item.to_node));
            ewr_data = in_item.weight;
          end else begin
            src_nxt   = in_item.source;
            v_nxt     = '0;
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        // source starts at zero; an out-of-range source never matches
        nwr_en   = 1'b1;
        nwr_data = {1'b0, PRED_NONE,
                    (32'(src_r) == 32'(v_r)) ? {DIST_W{1'b0}} : INF_DIST};
        v_nxt    = v_r + 1'b1;
        if (v_r == V_LAST) begin
          v_nxt        = '0;
          round_nxt    = '0;
          best_vld_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        nrd_en    = 1'b1;
        p_vld_nxt = 1'b1;
        p_idx_nxt = v_r;
        v_nxt     = v_r + 1'b1;
        if (v_r == V_LAST) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_nxt = S_MARK;
      end
      S_MARK: begin
        // settle the chosen node and set up its matrix row
        nwr_en   = 1'b1;
        nwr_addr = best_idx_r;
        nwr_data = {1'b1, best_pred_r, best_r};
        du_nxt   = best_r;
        ea_nxt   = EA_W'(32'(best_idx_r) * NODES);
        v_nxt    = '0;
        if (best_r != INF_DIST) begin
          state_nxt = S_RELAX;
        end else if (round_r == ROUND_LAST) begin
          state_nxt = S_REP_RD;
        end else begin
          round_nxt    = round_r + 1'b1;
          best_vld_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      S_RELAX: begin
        nrd_en    = 1'b1;
        erd_en    = 1'b1;
        p_vld_nxt = 1'b1;
        p_idx_nxt = v_r;
        v_nxt     = v_r + 1'b1;
        ea_nxt    = ea_r + 1'b1;
        if (v_r == V_LAST) begin
          state_nxt = S_RELAX_END;
        end
      end
      S_RELAX_END: begin
        v_nxt = '0;
        if (round_r == ROUND_LAST) begin
          state_nxt = S_REP_RD;
        end else begin
          round_nxt    = round_r + 1'b1;
          best_vld_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      S_REP_RD: begin
        // hold the read until the output register can take the result
        if (rpt_free) begin
          nrd_en    = 1'b1;
          state_nxt = S_REP_LD;
        end
      end
      S_REP_LD: begin
        rpt_load = 1'b1;
        v_nxt    = v_r + 1'b1;
        if (v_r == RPT_LAST) begin
          v_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_REP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ea_r    <= '0;
      v_r     <= '0;
      round_r <= '0;
      p_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ea_r    <= ea_nxt;
      v_r     <= v_nxt;
      round_r <= round_nxt;
      p_vld_r <= p_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r       <= src_nxt;
    best_r      <= best_nxt;
    best_idx_r  <= best_idx_nxt;
    best_pred_r <= best_pred_nxt;
    best_vld_r  <= best_vld_nxt;
    du_r        <= du_nxt;
    p_idx_r     <= p_idx_nxt;
  end

  // edge matrix: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ewr_en) begin
      edge_mem[ewr_addr] <= ewr_data;
    end
    if (erd_en) begin
      erd_r <= edge_mem[ea_r];
    end
  end

  // node state: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (nwr_en) begin
      node_mem[nwr_addr] <= nwr_data;
    end
    if (nrd_en) begin
      nrd_r <= node_mem[nrd_addr];
    end
  end

  dgsp_report #(
    .NODES  (NODES),
    .IDX_W  (IDX_W),
    .PRED_W (PRED_W)
  ) u_report (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (rpt_load),
    .k         (v_r),
    .node_dist (n_dist),
    .pred      (n_pred),
    .last      (v_r == RPT_LAST),
    .free      (rpt_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

[verif/dgsp_path_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dgsp_path_checker: predicts and checks shortest-path reports
// Mirrors the edge matrix from accepted load transactions, runs its own
// Dijkstra pass on each accepted run transaction and compares every report
// leaving the block, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module dgsp_path_checker #(
  parameter int NODES = dgsp_pkg::NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  dgsp_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  dgsp_pkg::out_item_t out_item,
  output int unsigned         fail_count,
  output int unsigned         pending_reports
);
  import dgsp_pkg::*;

  logic [WEIGHT_W-1:0] edge_w [NODES][NODES];
  logic [DIST_W-1:0]   path_len [NODES];
  logic                visited [NODES];
  int unsigned         prev_hop [NODES];   // NODES marks no predecessor
  out_item_t           expected_reports [$];
  int unsigned         mismatches = 0;

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    // keep the log short on a badly broken block, count everything
    if (mismatches < 40)
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    out_item_t   want;
    out_item_t   rpt;
    int unsigned round, v, u, du, w, best, k, count, hop;
    logic        reach;

    if (!rst_n) begin
      for (v = 0; v < NODES; v++)
        for (k = 0; k < NODES; k++)
          edge_w[v][k] = '0;
      expected_reports.delete();
    end else begin
      // check the result side first; a run never reports in its own cycle
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          note_mismatch("report with nothing pending, node", out_item.node, 0);
        end else begin
          want = expected_reports.pop_front();
          if (out_item.node != want.node)
            note_mismatch("node", out_item.node, want.node);
          if (out_item.distance != want.distance)
            note_mismatch("distance", out_item.distance, want.distance);
          if (out_item.reachable != want.reachable)
            note_mismatch("reachable", out_item.reachable, want.reachable);
          if (out_item.parent != want.parent)
            note_mismatch("parent", out_item.parent, want.parent);
          if (out_item.has_parent != want.has_parent)
            note_mismatch("has_parent", out_item.has_parent, want.has_parent);
          if (out_item.last != want.last)
            note_mismatch("last", out_item.last, want.last);
        end
      end

      if (in_valid && in_ready) begin
        if (in_item.command == CMD_LOAD) begin
          if (in_item.from_node < NODES && in_item.to_node < NODES)
            edge_w[in_item.from_node][in_item.to_node] = in_item.weight;
        end else begin
          for (v = 0; v < NODES; v++) begin
            path_len[v] = INF_DIST;
            visited[v]  = 1'b0;
            prev_hop[v] = NODES;
          end
          if (in_item.source < NODES)
            path_len[in_item.source] = '0;

          for (round = 0; round + 1 < NODES; round++) begin
            // pick the closest unvisited node, highest index on a tie
            best = 32'hFFFF_FFFF;
            u    = 0;
            for (v = 0; v < NODES; v++) begin
              if (!visited[v] && path_len[v] <= best) begin
                best = path_len[v];
                u    = v;
              end
            end
            visited[u] = 1'b1;
            du         = path_len[u];
            // never relax out of an unreachable node
            if (du != INF_DIST) begin
              for (v = 0; v < NODES; v++) begin
                w = edge_w[u][v];
                if (!visited[v] && w != 0 && du + w < path_len[v]) begin
                  path_len[v] = DIST_W'(du + w);
                  prev_hop[v] = u;
                end
              end
            end
          end

          count = (NODES < MAX_RPT) ? NODES : MAX_RPT;
          for (k = 0; k < count; k++) begin
            reach          = (path_len[k] != INF_DIST);
            hop            = prev_hop[k];
            rpt.node       = k[NODE_W-1:0];
            rpt.distance   = reach ? path_len[k] : '0;
            rpt.reachable  = reach;
            rpt.has_parent = reach && (hop < NODES);
            rpt.parent     = rpt.has_parent ? hop[NODE_W-1:0] : '0;
            rpt.last       = (k + 1 == count);
            expected_reports.push_back(rpt);
          end
        end
      end
    end

    fail_count      <= mismatches;
    pending_reports <= expected_reports.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the dense-graph shortest path block
// Loads edge weights and launches runs through the input channel, stalls
// the result channel at random and leaves prediction and compare to the
// checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import dgsp_pkg::*;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int unsigned fail_count;
  int unsigned pending_reports;

  // idle odds in percent for each side; the stimulus moves them per phase
  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 63;
  int unsigned sent          = 0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dense_graph_shortest_path u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  dgsp_path_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .fail_count      (fail_count),
    .pending_reports (pending_reports)
  );

  // Drop ready on the result side at random; one assignment per falling edge.
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Build a load transaction; the unused source field still carries noise.
  function automatic in_item_t edge_load(input int unsigned from, input int unsigned to,
                                         input int unsigned w);
    in_item_t it;
    int unsigned noise;
    noise        = $urandom;
    it.command   = CMD_LOAD;
    it.from_node = from[NODE_W-1:0];
    it.to_node   = to[NODE_W-1:0];
    it.weight    = w[WEIGHT_W-1:0];
    it.source    = noise[NODE_W-1:0];
    return it;
  endfunction

  // Build a run transaction; the edge fields are ignored, so randomize them.
  function automatic in_item_t path_run(input int unsigned src);
    in_item_t it;
    int unsigned noise;
    noise        = $urandom;
    it.command   = CMD_RUN;
    it.from_node = noise[NODE_W-1:0];
    it.to_node   = noise[2*NODE_W-1:NODE_W];
    it.weight    = noise[2*NODE_W+WEIGHT_W-1:2*NODE_W];
    it.source    = src[NODE_W-1:0];
    return it;
  endfunction

  // Present one transaction, starting and ending at a falling edge. Valid is
  // dropped only for idle cycles, so back-to-back transactions keep it high.
  task automatic send(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // One random episode: mostly a well-formed graph edit followed by a run,
  // sometimes loose noise.
  task automatic random_episode();
    int unsigned kind, n, k, base, span, a, b, w, src;
    kind = $urandom_range(99);
    base = $urandom_range(63);
    if (kind < 25) begin
      // heavy chain from base, wrapping past node 63: long, deep distances
      n = $urandom_range(4, 12);
      for (k = 0; k < n; k++)
        send(edge_load(base + k, base + k + 1, $urandom_range(200, 255)));
      send(path_run(base));
    end else if (kind < 85) begin
      // dense cluster with small weights for ties, removals and max weights
      span = $urandom_range(4, 12);
      n    = $urandom_range(4, 14);
      for (k = 0; k < n; k++) begin
        a = base + $urandom_range(span - 1);
        b = base + $urandom_range(span - 1);
        case ($urandom_range(9))
          0:       w = 0;
          1:       w = 255;
          2, 3:    w = $urandom_range(1, 4);
          default: w = $urandom_range(1, 255);
        endcase
        if ($urandom_range(9) == 0) begin
          a = $urandom_range(63);
          b = $urandom_range(63);
        end
        send(edge_load(a, b, w));
      end
      src = base;
      if ($urandom_range(3) == 0)
        src = $urandom_range(63);
      send(path_run(src));
    end else begin
      // loose writes anywhere, a run only now and then
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++)
        send(edge_load($urandom_range(63), $urandom_range(63), $urandom_range(255)));
      if ($urandom_range(1) == 0)
        send(path_run($urandom_range(63)));
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned target;

    // hold reset, then release it on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, run under the first idling mix.
    // Empty matrix: only the source is reachable, at distance 0, no parent.
    send(path_run(0));
    // Two equal paths into node 7: the tie goes to node 6, and the later
    // offer through node 5 is no improvement, so the parent stays 6.
    send(edge_load(0, 5, 10));
    send(edge_load(0, 6, 10));
    send(edge_load(5, 7, 1));
    send(edge_load(6, 7, 1));
    // self loop and an edge back into the visited source: never relaxed
    send(edge_load(7, 7, 3));
    send(edge_load(7, 0, 1));
    // maximum weight and the highest node index on both ends
    send(edge_load(0, 63, 255));
    send(edge_load(63, 62, 255));
    send(edge_load(63, 63, 255));
    send(path_run(0));
    // zero weight removes the edge, so node 7 is now reached through node 5
    send(edge_load(0, 6, 0));
    send(path_run(0));
    // highest source index; node 6 is now unreachable from everywhere
    send(path_run(63));
    send(path_run(7));

    // Random part in three idling mixes: sender light / receiver heavy,
    // then the reverse, then no idling at all.
    target = sent;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target += 100;
      while (sent < target) random_episode();
    end
    in_valid <= 1'b0;

    // drain outstanding reports, then watch a while for strays
    while (pending_reports != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    if (fail_count == 0 && pending_reports == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Hard stop: the clearing pass plus a full run on every one of some 330
  // transactions still fits several times over.
  initial begin
    #60ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
